>>> rtl/core/crcpf_pkg.sv
// ----------------------------------------------------------------------------
// crcpf_pkg
// Shared types, constants and CRC helpers for the CRC-16 packet framer.
// ----------------------------------------------------------------------------
package crcpf_pkg;

	localparam int PREAMBLE_LEN  = 3;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int NUM_SLOTS     = 9;
	localparam logic [15:0] CRC_POLY      = 16'h8408;
	localparam logic [15:0] CRC_START_RST = 16'hFFFF;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PREAMBLE_FIRST  = 2'd0,
		REG_PREAMBLE_SECOND = 2'd1,
		REG_PREAMBLE_THIRD  = 2'd2,
		REG_CRC_START       = 2'd3
	} cfg_reg_t;

	// output byte slots of one input word, in emission order
	typedef enum logic [3:0] {
		SLOT_PRE0    = 4'd0,
		SLOT_PRE1    = 4'd1,
		SLOT_PRE2    = 4'd2,
		SLOT_KIND    = 4'd3,
		SLOT_LEN_LO  = 4'd4,
		SLOT_LEN_HI  = 4'd5,
		SLOT_PAYLOAD = 4'd6,
		SLOT_CRC_LO  = 4'd7,
		SLOT_CRC_HI  = 4'd8
	} slot_t;

	typedef logic [NUM_SLOTS-1:0] slot_mask_t;

	typedef struct packed {
		logic        frame_start;
		logic        frame_end;
		logic [7:0]  frame_kind;
		logic [15:0] declared_length;
		logic        byte_present;
		logic [7:0]  payload_byte;
	} item_t;

	typedef struct packed {
		logic [PREAMBLE_LEN-1:0][7:0] preamble;
		logic [15:0]                  crc_start;
	} cfg_t;

	typedef struct packed {
		logic emit;  // a byte moves into the output register this cycle
		logic last;  // it is the final byte of the current word
	} emit_ctl_t;

	// reflected CRC-16 update over one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// slots one word produces, given whether a frame is open before it
	function automatic slot_mask_t build_mask(input item_t it, input logic open_before);
		slot_mask_t m;
		logic       open_eff;
		open_eff = it.frame_start | open_before;
		m = '0;
		m[SLOT_PRE0]    = it.frame_start;
		m[SLOT_PRE1]    = it.frame_start;
		m[SLOT_PRE2]    = it.frame_start;
		m[SLOT_KIND]    = it.frame_start;
		m[SLOT_LEN_LO]  = it.frame_start;
		m[SLOT_LEN_HI]  = it.frame_start;
		m[SLOT_PAYLOAD] = it.byte_present & open_eff;
		m[SLOT_CRC_LO]  = it.frame_end & open_eff;
		m[SLOT_CRC_HI]  = it.frame_end & open_eff;
		return m;
	endfunction

	function automatic slot_t lowest_slot(input slot_mask_t m);
		slot_t s;
		s = SLOT_PRE0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (m[i]) s = slot_t'(4'(i));
		end
		return s;
	endfunction

	function automatic slot_mask_t clear_lowest(input slot_mask_t m);
		return m & (m - slot_mask_t'(1));
	endfunction

endpackage

>>> rtl/core/crcpf_if.sv
// ----------------------------------------------------------------------------
// crcpf channel interfaces
// Valid/ready channels for input words, output bytes and register writes.
// ----------------------------------------------------------------------------
interface crcpf_in_if;
	logic        valid;
	logic        ready;
	logic        frame_start;
	logic        frame_end;
	logic [7:0]  frame_kind;
	logic [15:0] declared_length;
	logic        byte_present;
	logic [7:0]  payload_byte;

	modport source (output valid, frame_start, frame_end, frame_kind, declared_length,
		byte_present, payload_byte, input ready);
	modport sink (input valid, frame_start, frame_end, frame_kind, declared_length,
		byte_present, payload_byte, output ready);
endinterface

interface crcpf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_last;

	modport source (output valid, out_byte, run_last, frame_last, input ready);
	modport sink (input valid, out_byte, run_last, frame_last, output ready);
endinterface

interface crcpf_cfg_if import crcpf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/crcpf_cfg_regs.sv
// ----------------------------------------------------------------------------
// crcpf_cfg_regs
// Register file for the preamble bytes and the CRC start value.
// ----------------------------------------------------------------------------
module crcpf_cfg_regs import crcpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	crcpf_cfg_if.sink  cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.preamble  <= '0;
			regs_q.crc_start <= CRC_START_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_PREAMBLE_FIRST:  regs_q.preamble[0] <= cfg.data[7:0];
				REG_PREAMBLE_SECOND: regs_q.preamble[1] <= cfg.data[7:0];
				REG_PREAMBLE_THIRD:  regs_q.preamble[2] <= cfg.data[7:0];
				REG_CRC_START:       regs_q.crc_start   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/crcpf_item_stage.sv
// ----------------------------------------------------------------------------
// crcpf_item_stage
// Input register: holds one word and the mask of byte slots still to send.
// ----------------------------------------------------------------------------
module crcpf_item_stage import crcpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	crcpf_in_if.sink    item_in,
	input  emit_ctl_t   ctl,
	output logic        valid,
	output item_t       item,
	output slot_mask_t  mask
);

	logic       valid_s1;
	item_t      item_s1;
	slot_mask_t mask_s1;
	logic       open_q;     // frame open once every accepted word is done
	item_t      in_item;
	slot_mask_t in_mask;
	logic       accept;

	assign in_item = '{frame_start: item_in.frame_start, frame_end: item_in.frame_end,
		frame_kind: item_in.frame_kind, declared_length: item_in.declared_length,
		byte_present: item_in.byte_present, payload_byte: item_in.payload_byte};
	assign in_mask = build_mask(in_item, open_q);

	// take a new word when empty or when the held word sends its last byte
	assign item_in.ready = !valid_s1 || (ctl.emit && ctl.last);
	assign accept        = item_in.valid && item_in.ready;

	assign valid = valid_s1;
	assign item  = item_s1;
	assign mask  = mask_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			open_q   <= 1'b0;
		end else begin
			if (accept) begin
				// drop words that produce nothing
				valid_s1 <= (in_mask != '0);
				open_q   <= (in_item.frame_start | open_q) & ~in_item.frame_end;
			end else if (ctl.emit && ctl.last) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
			mask_s1 <= in_mask;
		end else if (ctl.emit) begin
			mask_s1 <= clear_lowest(mask_s1);
		end
	end

endmodule

>>> rtl/core/crcpf_emitter.sv
// ----------------------------------------------------------------------------
// crcpf_emitter
// Picks the next byte slot, runs the CRC and drives the output register.
// ----------------------------------------------------------------------------
module crcpf_emitter import crcpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        regs,
	input  logic        item_valid,
	input  item_t       item,
	input  slot_mask_t  mask,
	output emit_ctl_t   ctl,
	crcpf_out_if.source byte_out
);

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_last_q;
	logic        frame_last_q;
	logic [15:0] crc_q;
	slot_t       slot;
	logic [7:0]  next_byte;
	logic [15:0] crc_base;

	assign slot     = lowest_slot(mask);
	assign ctl.emit = item_valid && (!out_valid_q || byte_out.ready);
	assign ctl.last = (clear_lowest(mask) == '0);
	assign crc_base = (slot == SLOT_PRE0) ? regs.crc_start : crc_q;

	always_comb begin
		unique case (slot)
			SLOT_PRE0:    next_byte = regs.preamble[0];
			SLOT_PRE1:    next_byte = regs.preamble[1];
			SLOT_PRE2:    next_byte = regs.preamble[2];
			SLOT_KIND:    next_byte = item.frame_kind;
			SLOT_LEN_LO:  next_byte = item.declared_length[7:0];
			SLOT_LEN_HI:  next_byte = item.declared_length[15:8];
			SLOT_PAYLOAD: next_byte = item.payload_byte;
			SLOT_CRC_LO:  next_byte = crc_q[7:0];
			SLOT_CRC_HI:  next_byte = crc_q[15:8];
			default:      next_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			crc_q       <= CRC_START_RST;
		end else begin
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (byte_out.ready) begin
				out_valid_q <= 1'b0;
			end
			// header and payload bytes feed the CRC, the trailer does not
			if (ctl.emit && slot != SLOT_CRC_LO && slot != SLOT_CRC_HI) begin
				crc_q <= crc_byte(crc_base, next_byte);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_byte_q   <= next_byte;
			run_last_q   <= ctl.last;
			frame_last_q <= (slot == SLOT_CRC_HI);
		end
	end

	assign byte_out.valid      = out_valid_q;
	assign byte_out.out_byte   = out_byte_q;
	assign byte_out.run_last   = run_last_q;
	assign byte_out.frame_last = frame_last_q;

endmodule

>>> rtl/core/crc16_packet_framer_unit.sv
// ----------------------------------------------------------------------------
// crc16_packet_framer_unit
// Byte-stream packet framer with a reflected CRC-16 (poly 0x8408) trailer.
// ----------------------------------------------------------------------------
//
//   channel   dir   moves                          accepted when
//   item_in   in    one word (flags, kind, len,    item_in.valid & item_in.ready
//                   optional payload byte)
//   byte_out  out   one framed byte + last flags   byte_out.valid & byte_out.ready
//   cfg       in    register index + data          cfg.valid (ready tied high)
//
// Each word sends between zero and nine bytes, one per cycle while byte_out
// does not stall: a payload-only word sends one byte, a frame-start word six
// to nine, an end word adds two. The next word is taken in the same cycle
// the current word sends its last byte.
// Reset clears the word and output valid flags, the frame-open flag and the
// registers to their defaults. A stall on byte_out holds the output register
// and, through it, the word stage.
//
module crc16_packet_framer_unit import crcpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	crcpf_in_if.sink    item_in,
	crcpf_out_if.source byte_out,
	crcpf_cfg_if.sink   cfg
);

	cfg_t       regs;
	logic       item_valid;
	item_t      item;
	slot_mask_t mask;
	emit_ctl_t  ctl;

	// preamble and CRC start registers
	crcpf_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// hold the current word and track which of its bytes remain
	crcpf_item_stage u_item_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (item_in),
		.ctl     (ctl),
		.valid   (item_valid),
		.item    (item),
		.mask    (mask)
	);

	// advance one byte a cycle into the output register while it is not stalled, updating the CRC
	crcpf_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.item_valid (item_valid),
		.item       (item),
		.mask       (mask),
		.ctl        (ctl),
		.byte_out   (byte_out)
	);

endmodule

>>> tb/crcpf_frame_checker.sv
// ----------------------------------------------------------------------------
// crcpf_frame_checker
// Watches the word, byte and register channels of the framer, predicts the
// framed byte stream and compares each output byte in order.
// ----------------------------------------------------------------------------
module crcpf_frame_checker import crcpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	crcpf_in_if         words,
	crcpf_out_if        bytes,
	crcpf_cfg_if        regs,
	output int unsigned pending,
	output int unsigned fail_count,
	output int unsigned bytes_checked,
	output int unsigned frames_closed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [15:0] MCRF_POLY  = 16'h8408;
	localparam int unsigned REPORT_MAX = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       frame_last;
	} framed_byte_t;

	logic [7:0]   pre_bytes [PREAMBLE_LEN];
	logic [15:0]  crc_seed;
	logic [15:0]  crc_acc;
	logic         frame_live;
	framed_byte_t expected_bytes [$];
	int unsigned  misses;
	int unsigned  checked;
	int unsigned  closed;

	// reflected CRC, one message bit at a time
	function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r  = r >> 1;
			if (fb) r = r ^ MCRF_POLY;
		end
		return r;
	endfunction

	function automatic void push_framed(input logic [7:0] b, input logic fold,
		input logic ends_frame);
		framed_byte_t fb;
		fb.data       = b;
		fb.run_last   = 1'b0;
		fb.frame_last = ends_frame;
		expected_bytes.push_back(fb);
		if (fold) crc_acc = crc_fold(crc_acc, b);
	endfunction

	// expected bytes of one accepted word: header, payload, trailer
	function automatic void frame_word(input item_t w);
		int unsigned before_cnt;
		logic [15:0] trailer;
		before_cnt = expected_bytes.size();
		if (w.frame_start) begin
			crc_acc    = crc_seed;
			frame_live = 1'b1;
			for (int i = 0; i < PREAMBLE_LEN; i++) push_framed(pre_bytes[i], 1'b1, 1'b0);
			push_framed(w.frame_kind, 1'b1, 1'b0);
			push_framed(w.declared_length[7:0], 1'b1, 1'b0);
			push_framed(w.declared_length[15:8], 1'b1, 1'b0);
		end
		if (w.byte_present && frame_live) push_framed(w.payload_byte, 1'b1, 1'b0);
		if (w.frame_end && frame_live) begin
			trailer = crc_acc;
			push_framed(trailer[7:0], 1'b0, 1'b0);
			push_framed(trailer[15:8], 1'b0, 1'b1);
			frame_live = 1'b0;
		end
		if (expected_bytes.size() > before_cnt)
			expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		framed_byte_t seen;
		framed_byte_t want;
		item_t        w;
		if (!arst_n) begin
			for (int i = 0; i < PREAMBLE_LEN; i++) pre_bytes[i] = 8'h00;
			crc_seed   = CRC_START_RST;
			crc_acc    = CRC_START_RST;
			frame_live = 1'b0;
			expected_bytes.delete();
			misses  = 0;
			checked = 0;
			closed  = 0;
			pending       <= 0;
			fail_count    <= 0;
			bytes_checked <= 0;
			frames_closed <= 0;
		end else begin
			// compare first: a byte leaving now cannot belong to a word taken now
			if (bytes.valid && bytes.ready) begin
				seen.data       = bytes.out_byte;
				seen.run_last   = bytes.run_last;
				seen.frame_last = bytes.frame_last;
				checked++;
				if (seen.frame_last === 1'b1) closed++;
				if (expected_bytes.size() == 0) begin
					misses++;
					if (misses <= REPORT_MAX)
						$display("[%0t] byte %0d with nothing expected: %h run_last %b frame_last %b",
							$realtime, checked, seen.data, seen.run_last, seen.frame_last);
				end else begin
					want = expected_bytes.pop_front();
					if (seen !== want) begin
						misses++;
						if (misses <= REPORT_MAX)
							$display("[%0t] byte %0d: expected %h run_last %b frame_last %b, got %h run_last %b frame_last %b",
								$realtime, checked, want.data, want.run_last, want.frame_last,
								seen.data, seen.run_last, seen.frame_last);
					end
				end
			end
			if (regs.valid && regs.ready) begin
				case (cfg_reg_t'(regs.index))
					REG_PREAMBLE_FIRST: begin
						pre_bytes[0] = regs.data[7:0];
					end
					REG_PREAMBLE_SECOND: begin
						pre_bytes[1] = regs.data[7:0];
					end
					REG_PREAMBLE_THIRD: begin
						pre_bytes[2] = regs.data[7:0];
					end
					REG_CRC_START: begin
						crc_seed = regs.data;
					end
					default: begin
					end
				endcase
			end
			if (words.valid && words.ready) begin
				w.frame_start     = words.frame_start;
				w.frame_end       = words.frame_end;
				w.frame_kind      = words.frame_kind;
				w.declared_length = words.declared_length;
				w.byte_present    = words.byte_present;
				w.payload_byte    = words.payload_byte;
				frame_word(w);
			end
			pending       <= expected_bytes.size();
			fail_count    <= misses;
			bytes_checked <= checked;
			frames_closed <= closed;
		end
	end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives framing words and register writes into the CRC-16 packet framer with
// random idle gaps and output stalls; the frame checker beside the block
// predicts every byte and the verdict comes from its failure and pending counts.
// ----------------------------------------------------------------------------
module tb import crcpf_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          calm;
	int unsigned drain_hold;
	int unsigned words_sent;
	int unsigned frames_sent;
	int unsigned abandoned;
	int unsigned reg_writes;
	int unsigned setups;
	int unsigned pending_bytes;
	int unsigned fail_count;
	int unsigned bytes_checked;
	int unsigned frames_closed;

	crcpf_in_if  item_ch ();
	crcpf_out_if byte_ch ();
	crcpf_cfg_if cfg_ch ();

	crc16_packet_framer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_ch),
		.byte_out (byte_ch),
		.cfg      (cfg_ch)
	);

	crcpf_frame_checker frame_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.words         (item_ch),
		.bytes         (byte_ch),
		.regs          (cfg_ch),
		.pending       (pending_bytes),
		.fail_count    (fail_count),
		.bytes_checked (bytes_checked),
		.frames_closed (frames_closed)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Output side: after every byte taken, draw a random stall length and hold
	// ready low until it counts down. Calm stretches take every byte at once.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.ready <= 1'b0;
			drain_hold = 0;
		end else if (byte_ch.valid && byte_ch.ready) begin
			drain_hold = calm ? 0 : $urandom_range(0, 6);
			byte_ch.ready <= (drain_hold == 0);
		end else if (drain_hold != 0) begin
			drain_hold--;
			byte_ch.ready <= (drain_hold == 0);
		end else begin
			byte_ch.ready <= 1'b1;
		end
	end

	function automatic item_t make_word(input logic start, input logic stop,
		input logic [7:0] kind, input logic [15:0] len, input logic present,
		input logic [7:0] pay);
		item_t w;
		w.frame_start     = start;
		w.frame_end       = stop;
		w.frame_kind      = kind;
		w.declared_length = len;
		w.byte_present    = present;
		w.payload_byte    = pay;
		return w;
	endfunction

	// Offer one word after a random idle gap and hold it until it is taken.
	// Valid is lowered only for a real gap, so back-to-back words keep it high.
	task automatic send_word(input item_t w);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid           <= 1'b1;
		item_ch.frame_start     <= w.frame_start;
		item_ch.frame_end       <= w.frame_end;
		item_ch.frame_kind      <= w.frame_kind;
		item_ch.declared_length <= w.declared_length;
		item_ch.byte_present    <= w.byte_present;
		item_ch.payload_byte    <= w.payload_byte;
		do @(posedge clk); while (!item_ch.ready);
		words_sent++;
	endtask

	// Leave valid high between writes; the caller drops it after the last one.
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		reg_writes++;
	endtask

	// Stop offering words, wait for the last predicted byte, then give a
	// word that makes no bytes time to clear the sequencer (nine bytes max).
	task automatic settle();
		int unsigned guard;
		guard = 0;
		item_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending_bytes != 0 && guard < 5000);
		repeat (16) @(posedge clk);
	endtask

	// Load all four registers while the block is idle. Preamble writes can carry
	// nonzero upper data bits, which the block must drop.
	task automatic load_setup(input logic [15:0] p0, input logic [15:0] p1,
		input logic [15:0] p2, input logic [15:0] seed);
		settle();
		write_reg(REG_PREAMBLE_FIRST, p0);
		write_reg(REG_PREAMBLE_SECOND, p1);
		write_reg(REG_PREAMBLE_THIRD, p2);
		write_reg(REG_CRC_START, seed);
		cfg_ch.valid <= 1'b0;
		setups++;
	endtask

	// One frame with random content: a start word, a body of payload words
	// (now and then an empty one), and an end word unless the frame is to be
	// abandoned by the next start. Now and then one start word also ends it.
	task automatic random_frame(input bit finish, output int unsigned n);
		int unsigned body;
		bit          one_shot;
		body     = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
		one_shot = finish && ($urandom_range(0, 5) == 0);
		send_word(make_word(1'b1, one_shot, 8'($urandom), 16'($urandom),
			1'($urandom), 8'($urandom)));
		n = 1;
		frames_sent++;
		if (!one_shot) begin
			for (int i = 0; i < body; i++) begin
				send_word(make_word(1'b0, 1'b0, 8'($urandom), 16'($urandom),
					($urandom_range(0, 7) != 0), 8'($urandom)));
				n++;
			end
			if (finish) begin
				send_word(make_word(1'b0, 1'b1, 8'($urandom), 16'($urandom),
					1'($urandom), 8'($urandom)));
				n++;
			end
		end
	endtask

	// Mostly well-formed frames; some abandoned ones and loose noise words.
	// Noise does not count toward the quota.
	task automatic run_phase(input int unsigned quota, input bit steady);
		int unsigned made;
		int unsigned n;
		int unsigned roll;
		made = 0;
		while (made < quota) begin
			calm <= steady || ($urandom_range(0, 5) == 0);
			roll = $urandom_range(0, 19);
			if (roll < 2) begin
				send_word(make_word(1'($urandom), 1'($urandom), 8'($urandom),
					16'($urandom), 1'($urandom), 8'($urandom)));
			end else if (roll < 4) begin
				random_frame(1'b0, n);
				made += n;
				abandoned++;
			end else begin
				random_frame(1'b1, n);
				made += n;
			end
		end
	endtask

	initial begin
		// drive every input from time zero; hold reset low before releasing it
		arst_n                  <= 1'b0;
		calm                    <= 1'b0;
		item_ch.valid           <= 1'b0;
		item_ch.frame_start     <= 1'b0;
		item_ch.frame_end       <= 1'b0;
		item_ch.frame_kind      <= 8'h00;
		item_ch.declared_length <= 16'h0000;
		item_ch.byte_present    <= 1'b0;
		item_ch.payload_byte    <= 8'h00;
		cfg_ch.valid            <= 1'b0;
		cfg_ch.index            <= REG_PREAMBLE_FIRST;
		cfg_ch.data             <= 16'h0000;
		words_sent  = 0;
		frames_sent = 0;
		abandoned   = 0;
		reg_writes  = 0;
		setups      = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset registers (all-zero preamble, seed
		// 0xFFFF). Payload and end with no open frame, and an empty word,
		// must make nothing.
		send_word(make_word(1'b0, 1'b0, 8'hFF, 16'hFFFF, 1'b1, 8'hFF));
		send_word(make_word(1'b0, 1'b1, 8'h00, 16'h0000, 1'b0, 8'h00));
		send_word(make_word(1'b0, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h5A));
		// smallest header, two payload extremes, then close
		send_word(make_word(1'b1, 1'b0, 8'h00, 16'h0000, 1'b0, 8'hFF));
		send_word(make_word(1'b0, 1'b0, 8'h00, 16'h0000, 1'b1, 8'h00));
		send_word(make_word(1'b0, 1'b0, 8'h00, 16'h0000, 1'b1, 8'hFF));
		send_word(make_word(1'b0, 1'b1, 8'h00, 16'h0000, 1'b0, 8'h00));
		// a second end after the frame closed is dropped
		send_word(make_word(1'b0, 1'b1, 8'h00, 16'h0000, 1'b0, 8'h00));
		// start, payload and end in one word: all nine bytes
		send_word(make_word(1'b1, 1'b1, 8'hFF, 16'hFFFF, 1'b1, 8'hA5));
		// open a frame, then restart it without a trailer
		send_word(make_word(1'b1, 1'b0, 8'h5A, 16'h0102, 1'b1, 8'h3C));
		send_word(make_word(1'b1, 1'b0, 8'h81, 16'h8000, 1'b0, 8'h00));
		send_word(make_word(1'b0, 1'b1, 8'h00, 16'h0000, 1'b1, 8'h7E));
		send_word(make_word(1'b1, 1'b1, 8'h01, 16'h0001, 1'b0, 8'h00));

		// opposite extremes: all-ones preamble, zero seed
		load_setup(16'hFFFF, 16'h00FF, 16'hFFFF, 16'h0000);
		send_word(make_word(1'b1, 1'b0, 8'hC3, 16'h00FF, 1'b1, 8'h01));
		send_word(make_word(1'b0, 1'b1, 8'h00, 16'h0000, 1'b1, 8'h80));
		send_word(make_word(1'b1, 1'b1, 8'h00, 16'hFF00, 1'b0, 8'h00));

		// random phases, each under its own register setting
		load_setup(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_phase(40, 1'b0);
		load_setup(16'h0055, 16'hFFAA, 16'h007E, 16'h1D0F);
		run_phase(35, 1'b1);
		calm <= 1'b0;
		load_setup(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_phase(40, 1'b0);
		load_setup(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		run_phase(35, 1'b0);
		load_setup(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_phase(40, 1'b0);

		// drain, then give the verdict
		settle();
		$display("covered %0d words in %0d frames (%0d abandoned), %0d register writes over %0d settings",
			words_sent, frames_sent, abandoned, reg_writes, setups + 1);
		$display("%0d framed bytes checked, %0d trailers closed", bytes_checked, frames_closed);
		if (pending_bytes != 0)
			$display("%0d expected bytes never came out", pending_bytes);
		if (fail_count == 0 && pending_bytes == 0) begin
			$display("PASS crc16_packet_framer_unit");
		end else begin
			$display("FAIL crc16_packet_framer_unit");
		end
		$finish;
	end

	// hard stop if a handshake hangs
	initial begin
		#(2_000_000);
		$display("timeout: a channel stopped moving");
		$display("FAIL crc16_packet_framer_unit");
		$finish;
	end

endmodule
